// ===== design/uhc_pkg.sv =====
// ----------------------------------------------------------------------------
// uhc_pkg
// Shared types and constants for the IPv4/UDP header checker.
// ----------------------------------------------------------------------------
package uhc_pkg;

   localparam int MaxPacketBytes = 2048;
   localparam int CountW         = $clog2(MaxPacketBytes + 1);
   // Position compares must reach header length + 5 (up to 65)
   localparam int PosW           = (CountW > 7) ? CountW : 7;
   localparam int WideW          = 17;

   localparam logic [3:0]  IhlMask     = 4'hf;
   localparam logic [15:0] SumGood     = 16'hFFFF;
   localparam int          MinIpBytes  = 20;
   localparam int          UdpHdrBytes = 8;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_TOTAL_LEN  = 3'd2,
      STATUS_NO_UDP     = 3'd3,
      STATUS_UDP_SHORT  = 3'd4,
      STATUS_UDP_OVERRUN= 3'd5,
      STATUS_CHECKSUM   = 3'd6,
      STATUS_OVERFLOW   = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] source_address;
      logic [15:0] source_port;
      logic [6:0]  payload_offset;
      logic [15:0] payload_length;
   } rsp_type;

   // Parser state at the end of one buffer
   typedef struct packed {
      logic              overflow;
      logic [CountW-1:0] byte_count;
      logic [5:0]        header_length;
      logic [15:0]       total_length;
      logic [15:0]       datagram_length;
      logic [15:0]       header_sum;
      logic [31:0]       address;
      logic [15:0]       port;
   } snap_type;

endpackage

// ===== design/uhc_parser.sv =====
// ----------------------------------------------------------------------------
// uhc_parser
// Per-byte field capture and header sum; registers a snapshot on the last beat.
// ----------------------------------------------------------------------------
module uhc_parser
   import uhc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     snap_valid,
   input  logic     snap_ready,
   output snap_type snap_data
);

   logic [CountW-1:0] count_ff, count_in;
   logic [5:0]        hl_ff, hl_in;
   logic [15:0]       total_ff, total_in;
   logic [15:0]       dlen_ff, dlen_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        hold_ff, hold_in;
   logic [31:0]       addr_ff, addr_in;
   logic [15:0]       port_ff, port_in;
   logic              ovf_ff, ovf_in;
   logic              snap_valid_ff, snap_valid_in;
   snap_type          snap_ff, snap_in;

   logic              fire;
   logic              take;
   logic [PosW-1:0]   pos;
   logic [PosW-1:0]   hl_pos;
   logic [5:0]        hl_cur;
   logic [7:0]        b;
   logic [16:0]       sum_wide;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign fire       = in_valid && in_ready;
   assign b          = in_data.packet_byte;
   assign take       = !ovf_ff && (count_ff < CountW'(MaxPacketBytes));
   assign pos        = PosW'(count_ff);
   assign hl_cur     = (count_ff == '0) ? {b[3:0] & IhlMask, 2'b00} : hl_ff;
   assign hl_pos     = PosW'(hl_cur);
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, hold_ff, b};
   assign snap_valid = snap_valid_ff;
   assign snap_data  = snap_ff;

   always_comb begin
      count_in = count_ff;
      hl_in    = hl_ff;
      total_in = total_ff;
      dlen_in  = dlen_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      addr_in  = addr_ff;
      port_in  = port_ff;
      ovf_in   = ovf_ff;
      if (fire) begin
         if (take) begin
            hl_in    = hl_cur;
            count_in = count_ff + 1'b1;
            if (pos == PosW'(2)) total_in[15:8] = b;
            else if (pos == PosW'(3)) total_in[7:0] = b;
            if (pos >= PosW'(12) && pos <= PosW'(15)) addr_in = {addr_ff[23:0], b};
            if (pos == hl_pos) port_in[15:8] = b;
            else if (pos == hl_pos + PosW'(1)) port_in[7:0] = b;
            if (pos == hl_pos + PosW'(4)) dlen_in[15:8] = b;
            else if (pos == hl_pos + PosW'(5)) dlen_in[7:0] = b;
            if (pos < hl_pos) begin
               if (!pos[0]) begin
                  hold_in = b;
               end else begin
                  // end-around carry: subtracting 0xFFFF is adding one
                  sum_in = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
               end
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      snap_in.overflow        = ovf_in;
      snap_in.byte_count      = count_in;
      snap_in.header_length   = hl_in;
      snap_in.total_length    = total_in;
      snap_in.datagram_length = dlen_in;
      snap_in.header_sum      = sum_in;
      snap_in.address         = addr_in;
      snap_in.port            = port_in;
      snap_valid_in = snap_valid_ff && !snap_ready;
      if (fire && in_data.last_byte) snap_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && in_data.last_byte)) begin
         count_ff <= '0;
         hl_ff    <= '0;
         total_ff <= '0;
         dlen_ff  <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         addr_ff  <= '0;
         port_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         hl_ff    <= hl_in;
         total_ff <= total_in;
         dlen_ff  <= dlen_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         addr_ff  <= addr_in;
         port_ff  <= port_in;
         ovf_ff   <= ovf_in;
      end
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
      if (fire && in_data.last_byte) snap_ff <= snap_in;
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && in_data.last_byte) |=> (count_ff == '0 && !ovf_ff))
      else $error("parser state not cleared after last beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxPacketBytes))
      else $error("byte count past limit");

   a_overflow_freezes: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !(fire && in_data.last_byte)) |=> $stable(count_ff))
      else $error("byte count moved after overflow");

endmodule

// ===== design/uhc_checker.sv =====
// ----------------------------------------------------------------------------
// uhc_checker
// Ordered length and checksum checks on a buffer snapshot; result register.
// ----------------------------------------------------------------------------
module uhc_checker
   import uhc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     snap_valid,
   output logic     snap_ready,
   input  snap_type snap_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   logic             out_valid_ff;
   rsp_type          out_ff, out_in;
   logic [WideW-1:0] n;
   logic [WideW-1:0] hl_w;
   logic [WideW-1:0] dlen_w;
   status_type       status;

   assign snap_ready = !out_valid_ff || out_ready;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_ff;

   assign n      = WideW'(snap_data.byte_count);
   assign hl_w   = WideW'(snap_data.header_length);
   assign dlen_w = WideW'(snap_data.datagram_length);

   always_comb begin
      if (n < WideW'(MinIpBytes))                                   status = STATUS_SHORT;
      else if (WideW'(snap_data.total_length) > n)                  status = STATUS_TOTAL_LEN;
      else if (hl_w + WideW'(UdpHdrBytes) > n)                      status = STATUS_NO_UDP;
      else if (dlen_w < WideW'(UdpHdrBytes))                        status = STATUS_UDP_SHORT;
      else if (hl_w + dlen_w > n)                                   status = STATUS_UDP_OVERRUN;
      else if (snap_data.header_sum != SumGood)                     status = STATUS_CHECKSUM;
      else                                                          status = STATUS_OK;

      if (snap_data.overflow) begin
         out_in = '0;
         out_in.status = STATUS_OVERFLOW;
      end else begin
         out_in.status         = status;
         out_in.source_address = snap_data.address;
         out_in.source_port    = snap_data.port;
         out_in.payload_offset = 7'(snap_data.header_length) + 7'(UdpHdrBytes);
         out_in.payload_length = (status == STATUS_OK) ?
                                 (snap_data.datagram_length - 16'(UdpHdrBytes)) : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         out_valid_ff <= snap_valid;
      end
      if (snap_valid && snap_ready) out_ff <= out_in;
   end

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == STATUS_OVERFLOW) |->
      (out_ff.source_address == '0 && out_ff.source_port == '0 &&
       out_ff.payload_offset == '0 && out_ff.payload_length == '0))
      else $error("overflow result carries nonzero fields");

   a_fail_no_length: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != STATUS_OK) |-> out_ff.payload_length == '0)
      else $error("payload length set on failing buffer");

   a_load_on_take: assert property (@(posedge clock) disable iff (reset)
      (snap_valid && snap_ready) |=> out_valid_ff)
      else $error("snapshot taken but no result held");

endmodule

// ===== design/ipv4_udp_header_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_udp_header_checker
// IPv4/UDP header parse and check with ones'-complement header sum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packet byte per beat, starting at the IP header, with
//   last_byte set on the final byte of the buffer. Each byte updates the
//   captured fields and the header sum in the same cycle it is accepted.
//   rsp_* carries one result per buffer, issued only for the last beat.
//   Throughput: one byte per cycle while req_ready is high; buffers may follow back to back.
//   Result path: the last beat loads the snapshot register, then check logic
//   feeds the result register.
//   A stalled rsp_ready holds the result; the snapshot stage still takes one
//   more buffer end, and req_ready drops only when both stages are full.
//   Reset clears the byte count, all captures and both valid flags.
//   Buffers longer than the packet limit report the overflow status with all
//   other fields zero.
// ----------------------------------------------------------------------------
module ipv4_udp_header_checker
   import uhc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     snap_valid;
   logic     snap_ready;
   snap_type snap_data;

   uhc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data)
   );

   uhc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap_data  (snap_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

endmodule
